[rtl/core/svpwm_pkg.sv]
`timescale 1ns / 1ps

package svpwm_pkg;

  // default widths of the angle and of the duty fraction
  localparam int unsigned ANGLE_BITS_DEF = 16;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // pipeline depths
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned SQRT_STEPS   = 24;
  localparam int unsigned DIV_STEPS    = 32;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // index path: radicand, root steps, divide steps, clamp
  localparam int unsigned LAT_INDEX = 1 + SQRT_STEPS + DIV_STEPS + 1;
  // angle path: setup, vectoring steps, sector split, reciprocal multiply
  localparam int unsigned LAT_ANGLE = 1 + CORDIC_STEPS + 2;

  // datapath widths
  localparam int unsigned ATAN_W = 41;
  localparam int unsigned SINE_W = 33;
  localparam int unsigned T_W    = 36;

  // fixed-point constants
  localparam logic [16:0]          M_LIMIT      = 17'd37814;
  localparam logic signed [T_W-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [31:0]   SQRT3_Q30    = 32'sd1859775394;
  localparam logic signed [SINE_W-1:0] CORDIC_K_Q30 = 33'sd652032874;
  localparam logic [29:0]          SIXTY_DEG    = 30'd715827882;
  localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]          HALF_TURN    = 32'h8000_0000;
  localparam logic [32:0]          RECIP_3      = 33'h0_AAAA_AAAB;

  // register reset values and register indexes
  localparam logic [14:0] SUPPLY_RST = 15'd3072;
  localparam logic [15:0] PERIOD_RST = 16'd300;
  localparam logic [1:0]  CFG_SUPPLY = 2'd0;
  localparam logic [1:0]  CFG_PERIOD = 2'd1;

  // sector codes
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;
  localparam logic [2:0] SECTOR_5 = 3'd5;
  localparam logic [2:0] SECTOR_6 = 3'd6;

  // arctangent of 2^-i as turn fraction, 2^32 = one turn
  localparam logic [31:0] ARC_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // one classified vector between front and back
  typedef struct packed {
    logic signed [15:0] volt_q;
    logic signed [15:0] volt_d;
    logic [15:0]        elec_angle;
    logic               mag_path;
    logic [30:0]        q_sq;
    logic [30:0]        d_sq;
  } svpwm_item_t;

endpackage

[rtl/core/svpwm_front.sv]
`timescale 1ns / 1ps

module svpwm_front import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] volt_q_i,
  input  logic signed [15:0] volt_d_i,
  input  logic [15:0]        elec_angle_i,
  input  logic               queue_full_i,
  output logic               push_o,
  output svpwm_item_t        item_o
);

  logic        item_valid_q, item_valid_d;
  svpwm_item_t item_q;
  logic        accept;
  logic signed [31:0] q_sq_full, d_sq_full;

  // transaction handshake toward the queue
  assign busy   = item_valid_q && queue_full_i;
  assign push_o = item_valid_q && !queue_full_i;
  assign accept = start && !busy;
  assign item_o = item_q;

  always_comb begin
    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = 1'b1;
    end else if (push_o) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  // squares for the magnitude and path selection
  assign q_sq_full = volt_q_i * volt_q_i;
  assign d_sq_full = volt_d_i * volt_d_i;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.volt_q     <= volt_q_i;
      item_q.volt_d     <= volt_d_i;
      item_q.elec_angle <= elec_angle_i;
      item_q.mag_path   <= (volt_d_i != 16'sd0);
      item_q.q_sq       <= q_sq_full[30:0];
      item_q.d_sq       <= d_sq_full[30:0];
    end
  end

endmodule

[rtl/core/svpwm_queue.sv]
`timescale 1ns / 1ps

module svpwm_queue import svpwm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  svpwm_item_t item_i,
  output logic        full_o,
  output logic        valid_o,
  output svpwm_item_t item_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  svpwm_item_t       mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              pop;

  // the back end takes an entry every cycle one is present
  assign pop     = (count_q != '0);
  assign valid_o = pop;
  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[rtl/core/svpwm_index.sv]
`timescale 1ns / 1ps

module svpwm_index import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  svpwm_item_t        item_i,
  input  logic [14:0]        supply_i,
  output logic               valid_o,
  output logic signed [16:0] m_o
);

  localparam int unsigned RAD_W  = 48;
  localparam int unsigned ROOT_W = SQRT_STEPS;
  localparam int unsigned REM_W  = 26;

  // radicand stage
  logic               e_valid_q;
  logic [RAD_W-1:0]   e_rad_q;
  logic signed [15:0] e_q_q;
  logic               e_mag_q;

  // root stages
  logic               sq_valid_q [SQRT_STEPS];
  logic [RAD_W-1:0]   sq_rad_q   [SQRT_STEPS];
  logic [REM_W-1:0]   sq_rem_q   [SQRT_STEPS];
  logic [ROOT_W-1:0]  sq_root_q  [SQRT_STEPS];
  logic signed [15:0] sq_q_q     [SQRT_STEPS];
  logic               sq_mag_q   [SQRT_STEPS];

  // divide stages
  logic               dv_valid_q [DIV_STEPS];
  logic [31:0]        dv_n_q     [DIV_STEPS];
  logic [14:0]        dv_rem_q   [DIV_STEPS];
  logic [31:0]        dv_quo_q   [DIV_STEPS];
  logic               dv_neg_q   [DIV_STEPS];

  logic               m_valid_q;
  logic signed [16:0] m_q;

  logic [14:0]        den;
  logic [31:0]        n0;
  logic               neg0;
  logic [15:0]        q_abs;
  logic signed [15:0] q_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e_rad_q <= {32'(item_i.q_sq) + 32'(item_i.d_sq), 16'b0};
    e_q_q   <= item_i.volt_q;
    e_mag_q <= item_i.mag_path;
  end

  // integer square root, two radicand bits per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [RAD_W-1:0]   rad_in;
    logic [REM_W-1:0]   rem_in;
    logic [ROOT_W-1:0]  root_in;
    logic signed [15:0] q_in;
    logic               mag_in, v_in;
    logic [REM_W+1:0]   rem_sh, trial;

    if (k == 0) begin : g_first
      assign rad_in  = e_rad_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign q_in    = e_q_q;
      assign mag_in  = e_mag_q;
      assign v_in    = e_valid_q;
    end else begin : g_next
      assign rad_in  = sq_rad_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign q_in    = sq_q_q[k-1];
      assign mag_in  = sq_mag_q[k-1];
      assign v_in    = sq_valid_q[k-1];
    end

    assign rem_sh = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
    assign trial  = (REM_W+2)'({root_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_valid_q[k] <= 1'b0;
      end else begin
        sq_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      sq_rad_q[k] <= rad_in;
      sq_q_q[k]   <= q_in;
      sq_mag_q[k] <= mag_in;
      if (rem_sh >= trial) begin
        sq_rem_q[k]  <= REM_W'(rem_sh - trial);
        sq_root_q[k] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_q[k]  <= REM_W'(rem_sh);
        sq_root_q[k] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // dividend: magnitude over supply, or signed q over supply
  assign den    = (supply_i == '0) ? 15'd1 : supply_i;
  assign q_last = sq_q_q[SQRT_STEPS-1];
  assign q_abs  = q_last[15] ? 16'(-q_last) : 16'(q_last);
  assign n0     = sq_mag_q[SQRT_STEPS-1] ? {sq_root_q[SQRT_STEPS-1], 8'b0}
                                         : {q_abs, 16'b0};
  assign neg0   = !sq_mag_q[SQRT_STEPS-1] && q_last[15];

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [31:0] n_in, quo_in;
    logic [14:0] rem_in;
    logic        neg_in, v_in;
    logic [15:0] r;
    logic        ge;

    if (j == 0) begin : g_first
      assign n_in   = n0;
      assign quo_in = '0;
      assign rem_in = '0;
      assign neg_in = neg0;
      assign v_in   = sq_valid_q[SQRT_STEPS-1];
    end else begin : g_next
      assign n_in   = dv_n_q[j-1];
      assign quo_in = dv_quo_q[j-1];
      assign rem_in = dv_rem_q[j-1];
      assign neg_in = dv_neg_q[j-1];
      assign v_in   = dv_valid_q[j-1];
    end

    assign r  = {rem_in, n_in[31-j]};
    assign ge = (r >= {1'b0, den});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_valid_q[j] <= 1'b0;
      end else begin
        dv_valid_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_n_q[j]   <= n_in;
      dv_neg_q[j] <= neg_in;
      dv_quo_q[j] <= {quo_in[30:0], ge};
      dv_rem_q[j] <= ge ? 15'(r - {1'b0, den}) : r[14:0];
    end
  end

  // clamp to the linear range and restore the sign
  logic [16:0] quo_clamped;
  assign quo_clamped = (dv_quo_q[DIV_STEPS-1] > 32'(M_LIMIT)) ? M_LIMIT
                                                              : dv_quo_q[DIV_STEPS-1][16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= dv_valid_q[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= dv_neg_q[DIV_STEPS-1] ? -$signed(quo_clamped) : $signed(quo_clamped);
  end

  assign valid_o = m_valid_q;
  assign m_o     = m_q;

endmodule

[rtl/core/svpwm_angle.sv]
`timescale 1ns / 1ps

module svpwm_angle import svpwm_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic               clk_i,
  input  svpwm_item_t        item_i,
  output logic [29:0]        alpha_o,
  output logic [2:0]         sector_o
);

  localparam int unsigned PAD = LAT_INDEX - LAT_ANGLE;

  // setup stage: left half plane turned by half a turn
  logic signed [ATAN_W-1:0] a0_x_q, a0_y_q;
  logic [31:0]              a0_z_q;
  logic [15:0]              a0_angle_q;
  logic                     a0_mag_q;

  logic signed [ATAN_W-1:0] at_x_q     [CORDIC_STEPS];
  logic signed [ATAN_W-1:0] at_y_q     [CORDIC_STEPS];
  logic [31:0]              at_z_q     [CORDIC_STEPS];
  logic [15:0]              at_angle_q [CORDIC_STEPS];
  logic                     at_mag_q   [CORDIC_STEPS];

  logic [30:0]              half_r_q;
  logic [2:0]               sec_q;
  logic [29:0]              alpha_q;
  logic [2:0]               sec2_q;
  logic [29:0]              pad_alpha_q  [PAD];
  logic [2:0]               pad_sector_q [PAD];

  logic signed [ATAN_W-1:0] x_ext, y_ext;

  assign x_ext = ATAN_W'(item_i.volt_d) <<< 22;
  assign y_ext = ATAN_W'(item_i.volt_q) <<< 22;

  always_ff @(posedge clk_i) begin
    if (item_i.volt_d[15]) begin
      a0_x_q <= -x_ext;
      a0_y_q <= -y_ext;
      a0_z_q <= HALF_TURN;
    end else begin
      a0_x_q <= x_ext;
      a0_y_q <= y_ext;
      a0_z_q <= '0;
    end
    a0_angle_q <= item_i.elec_angle;
    a0_mag_q   <= item_i.mag_path;
  end

  // vectoring cordic for atan2(q, d)
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_atan
    logic signed [ATAN_W-1:0] x_in, y_in;
    logic [31:0]              z_in;
    logic [15:0]              angle_in;
    logic                     mag_in;

    if (k == 0) begin : g_first
      assign x_in     = a0_x_q;
      assign y_in     = a0_y_q;
      assign z_in     = a0_z_q;
      assign angle_in = a0_angle_q;
      assign mag_in   = a0_mag_q;
    end else begin : g_next
      assign x_in     = at_x_q[k-1];
      assign y_in     = at_y_q[k-1];
      assign z_in     = at_z_q[k-1];
      assign angle_in = at_angle_q[k-1];
      assign mag_in   = at_mag_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (!y_in[ATAN_W-1]) begin
        at_x_q[k] <= x_in + (y_in >>> k);
        at_y_q[k] <= y_in - (x_in >>> k);
        at_z_q[k] <= z_in + ARC_TAB[k];
      end else begin
        at_x_q[k] <= x_in - (y_in >>> k);
        at_y_q[k] <= y_in + (x_in >>> k);
        at_z_q[k] <= z_in - ARC_TAB[k];
      end
      at_angle_q[k] <= angle_in;
      at_mag_q[k]   <= mag_in;
    end
  end

  // reference angle, sector and offset within the sector
  logic [31:0]             theta;
  logic [ANGLE_BITS-1:0]   ang;
  logic [ANGLE_BITS+2:0]   six;
  logic [31:0]             r_wide;
  logic [63:0]             recip_prod;

  assign theta  = {at_angle_q[CORDIC_STEPS-1], 16'b0}
                + (at_mag_q[CORDIC_STEPS-1] ? at_z_q[CORDIC_STEPS-1] : QUARTER_TURN);
  assign ang    = theta[31 -: ANGLE_BITS];
  assign six    = {1'b0, ang, 2'b00} + {2'b00, ang, 1'b0};
  assign r_wide = {six[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};

  always_ff @(posedge clk_i) begin
    half_r_q <= r_wide[31:1];
    sec_q    <= six[ANGLE_BITS+2 -: 3] + 3'd1;
  end

  // divide by three through the reciprocal
  assign recip_prod = 64'(half_r_q) * 64'(RECIP_3);

  always_ff @(posedge clk_i) begin
    alpha_q <= recip_prod[62:33];
    sec2_q  <= sec_q;
  end

  // line up with the index path
  for (genvar p = 0; p < PAD; p++) begin : g_pad
    always_ff @(posedge clk_i) begin
      if (p == 0) begin
        pad_alpha_q[p]  <= alpha_q;
        pad_sector_q[p] <= sec2_q;
      end else begin
        pad_alpha_q[p]  <= pad_alpha_q[(p == 0) ? 0 : p-1];
        pad_sector_q[p] <= pad_sector_q[(p == 0) ? 0 : p-1];
      end
    end
  end

  assign alpha_o  = pad_alpha_q[PAD-1];
  assign sector_o = pad_sector_q[PAD-1];

endmodule

[rtl/core/svpwm_duty.sv]
`timescale 1ns / 1ps

module svpwm_duty import svpwm_pkg::*; #(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [16:0] m_i,
  input  logic [29:0]        alpha_i,
  input  logic [2:0]         sector_i,
  input  logic [15:0]        period_i,
  output logic               done_o,
  output logic [15:0]        duty_a_o,
  output logic [15:0]        duty_b_o,
  output logic [15:0]        duty_c_o,
  output logic [2:0]         sector_num_o
);

  localparam int unsigned FW = COUNT_BITS + 1;
  localparam int unsigned PW = FW + 16;

  // setup stage
  logic                     d0_valid_q;
  logic signed [SINE_W-1:0] d0_z1_q, d0_z2_q;
  logic signed [16:0]       d0_m_q;
  logic [2:0]               d0_sec_q;

  // two rotation cordics side by side
  logic                     cr_valid_q [CORDIC_STEPS];
  logic signed [SINE_W-1:0] c1_x_q [CORDIC_STEPS];
  logic signed [SINE_W-1:0] c1_y_q [CORDIC_STEPS];
  logic signed [SINE_W-1:0] c1_z_q [CORDIC_STEPS];
  logic signed [SINE_W-1:0] c2_x_q [CORDIC_STEPS];
  logic signed [SINE_W-1:0] c2_y_q [CORDIC_STEPS];
  logic signed [SINE_W-1:0] c2_z_q [CORDIC_STEPS];
  logic signed [16:0]       cr_m_q   [CORDIC_STEPS];
  logic [2:0]               cr_sec_q [CORDIC_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_valid_q <= 1'b0;
    end else begin
      d0_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_z1_q  <= $signed(SINE_W'(SIXTY_DEG) - SINE_W'(alpha_i));
    d0_z2_q  <= $signed(SINE_W'(alpha_i));
    d0_m_q   <= m_i;
    d0_sec_q <= sector_i;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_sine
    logic signed [SINE_W-1:0] x1, y1, z1, x2, y2, z2, arc;
    logic signed [16:0]       m_in;
    logic [2:0]               sec_in;
    logic                     v_in;

    if (k == 0) begin : g_first
      assign x1     = CORDIC_K_Q30;
      assign y1     = '0;
      assign z1     = d0_z1_q;
      assign x2     = CORDIC_K_Q30;
      assign y2     = '0;
      assign z2     = d0_z2_q;
      assign m_in   = d0_m_q;
      assign sec_in = d0_sec_q;
      assign v_in   = d0_valid_q;
    end else begin : g_next
      assign x1     = c1_x_q[k-1];
      assign y1     = c1_y_q[k-1];
      assign z1     = c1_z_q[k-1];
      assign x2     = c2_x_q[k-1];
      assign y2     = c2_y_q[k-1];
      assign z2     = c2_z_q[k-1];
      assign m_in   = cr_m_q[k-1];
      assign sec_in = cr_sec_q[k-1];
      assign v_in   = cr_valid_q[k-1];
    end

    assign arc = $signed({1'b0, ARC_TAB[k]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cr_valid_q[k] <= 1'b0;
      end else begin
        cr_valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (!z1[SINE_W-1]) begin
        c1_x_q[k] <= x1 - (y1 >>> k);
        c1_y_q[k] <= y1 + (x1 >>> k);
        c1_z_q[k] <= z1 - arc;
      end else begin
        c1_x_q[k] <= x1 + (y1 >>> k);
        c1_y_q[k] <= y1 - (x1 >>> k);
        c1_z_q[k] <= z1 + arc;
      end
      if (!z2[SINE_W-1]) begin
        c2_x_q[k] <= x2 - (y2 >>> k);
        c2_y_q[k] <= y2 + (x2 >>> k);
        c2_z_q[k] <= z2 - arc;
      end else begin
        c2_x_q[k] <= x2 + (y2 >>> k);
        c2_y_q[k] <= y2 - (x2 >>> k);
        c2_z_q[k] <= z2 + arc;
      end
      cr_m_q[k]   <= m_in;
      cr_sec_q[k] <= sec_in;
    end
  end

  // scale by sqrt3
  logic               m1_valid_q;
  logic signed [64:0] p1_q, p2_q;
  logic signed [16:0] m1_m_q;
  logic [2:0]         m1_sec_q;

  // scale by the modulation index
  logic               m2_valid_q;
  logic signed [49:0] s1_q, s2_q;
  logic [2:0]         m2_sec_q;

  // per-phase duty fractions
  logic                  t_valid_q;
  logic signed [T_W-1:0] ta_q, tb_q, tc_q;
  logic [2:0]            t_sec_q;
  logic signed [T_W-1:0] t1, t2, t0, half, ta, tb, tc;

  // fractions at count resolution
  logic          f_valid_q;
  logic [FW-1:0] fa_q, fb_q, fc_q;
  logic [2:0]    f_sec_q;

  // scaled to the period
  logic          p_valid_q;
  logic [PW-1:0] pa_q, pb_q, pc_q;
  logic [2:0]    p_sec_q;

  logic          done_q;
  logic [15:0]   duty_a_q, duty_b_q, duty_c_q;
  logic [2:0]    sector_q;

  logic [PW-COUNT_BITS-1:0] va, vb, vc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
      m2_valid_q <= 1'b0;
      t_valid_q  <= 1'b0;
      f_valid_q  <= 1'b0;
      p_valid_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      m1_valid_q <= cr_valid_q[CORDIC_STEPS-1];
      m2_valid_q <= m1_valid_q;
      t_valid_q  <= m2_valid_q;
      f_valid_q  <= t_valid_q;
      p_valid_q  <= f_valid_q;
      done_q     <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q     <= 65'(c1_y_q[CORDIC_STEPS-1]) * 65'(SQRT3_Q30);
    p2_q     <= 65'(c2_y_q[CORDIC_STEPS-1]) * 65'(SQRT3_Q30);
    m1_m_q   <= cr_m_q[CORDIC_STEPS-1];
    m1_sec_q <= cr_sec_q[CORDIC_STEPS-1];
  end

  always_ff @(posedge clk_i) begin
    s1_q     <= 50'($signed(p1_q[62:30])) * 50'(m1_m_q);
    s2_q     <= 50'($signed(p2_q[62:30])) * 50'(m1_m_q);
    m2_sec_q <= m1_sec_q;
  end

  // active and zero times, then the sector pattern
  always_comb begin
    t1   = T_W'($signed(s1_q[49:16]));
    t2   = T_W'($signed(s2_q[49:16]));
    t0   = ONE_Q30 - t1 - t2;
    half = t0 >>> 1;
    unique case (m2_sec_q)
      SECTOR_1: begin ta = t1 + t2 + half; tb = t2 + half;      tc = half;           end
      SECTOR_2: begin ta = t1 + half;      tb = t1 + t2 + half; tc = half;           end
      SECTOR_3: begin ta = half;           tb = t1 + t2 + half; tc = t2 + half;      end
      SECTOR_4: begin ta = half;           tb = t1 + half;      tc = t1 + t2 + half; end
      SECTOR_5: begin ta = t2 + half;      tb = half;           tc = t1 + t2 + half; end
      SECTOR_6: begin ta = t1 + t2 + half; tb = half;           tc = t1 + half;      end
      default:  begin ta = '0;             tb = '0;             tc = '0;             end
    endcase
  end

  always_ff @(posedge clk_i) begin
    ta_q    <= ta;
    tb_q    <= tb;
    tc_q    <= tc;
    t_sec_q <= m2_sec_q;
  end

  // negative fractions give zero counts
  always_ff @(posedge clk_i) begin
    fa_q    <= ta_q[T_W-1] ? '0 : FW'(ta_q >>> (30 - COUNT_BITS));
    fb_q    <= tb_q[T_W-1] ? '0 : FW'(tb_q >>> (30 - COUNT_BITS));
    fc_q    <= tc_q[T_W-1] ? '0 : FW'(tc_q >>> (30 - COUNT_BITS));
    f_sec_q <= t_sec_q;
  end

  always_ff @(posedge clk_i) begin
    pa_q    <= PW'(fa_q) * PW'(period_i);
    pb_q    <= PW'(fb_q) * PW'(period_i);
    pc_q    <= PW'(fc_q) * PW'(period_i);
    p_sec_q <= f_sec_q;
  end

  // saturate to the period
  assign va = pa_q[PW-1:COUNT_BITS];
  assign vb = pb_q[PW-1:COUNT_BITS];
  assign vc = pc_q[PW-1:COUNT_BITS];

  always_ff @(posedge clk_i) begin
    duty_a_q <= (va > (PW-COUNT_BITS)'(period_i)) ? period_i : va[15:0];
    duty_b_q <= (vb > (PW-COUNT_BITS)'(period_i)) ? period_i : vb[15:0];
    duty_c_q <= (vc > (PW-COUNT_BITS)'(period_i)) ? period_i : vc[15:0];
    sector_q <= p_sec_q;
  end

  assign done_o       = done_q;
  assign duty_a_o     = duty_a_q;
  assign duty_b_o     = duty_b_q;
  assign duty_c_o     = duty_c_q;
  assign sector_num_o = sector_q;

endmodule

[rtl/core/space_vector_pwm_duty.sv]
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// command   in         start / busy              volt_q_i, volt_d_i, elec_angle_i
// result    out        done_o strobe, no stall   duty_a_o, duty_b_o, duty_c_o, sector_num_o
// config    in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one command per clock; results come out in the order the commands were taken
// latency is set by the 24-step root, 32-step divider and 24-step sine cordic in series
// reset is asynchronous and active low; registers return to supply 3072, period 300
// busy stays low: the back end takes a queue entry every cycle, so the queue never fills
// results cannot be held off by the receiver

module space_vector_pwm_duty import svpwm_pkg::*; #(
  parameter int unsigned ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] volt_q_i,
  input  logic signed [15:0] volt_d_i,
  input  logic [15:0]        elec_angle_i,
  output logic               done_o,
  output logic [15:0]        duty_a_o,
  output logic [15:0]        duty_b_o,
  output logic [15:0]        duty_c_o,
  output logic [2:0]         sector_num_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic [14:0]        supply_q;
  logic [15:0]        period_q;
  logic               push, queue_full, queue_valid, idx_valid;
  svpwm_item_t        front_item, queue_item;
  logic signed [16:0] m;
  logic [29:0]        alpha;
  logic [2:0]         sector;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q <= SUPPLY_RST;
      period_q <= PERIOD_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SUPPLY) begin
        supply_q <= cfg_data_i[14:0];
      end else if (cfg_index_i == CFG_PERIOD) begin
        period_q <= cfg_data_i;
      end
    end
  end

  svpwm_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .volt_q_i     (volt_q_i),
    .volt_d_i     (volt_d_i),
    .elec_angle_i (elec_angle_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  svpwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  svpwm_index u_index (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (queue_valid),
    .item_i   (queue_item),
    .supply_i (supply_q),
    .valid_o  (idx_valid),
    .m_o      (m)
  );

  svpwm_angle #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_angle (
    .clk_i    (clk_i),
    .item_i   (queue_item),
    .alpha_o  (alpha),
    .sector_o (sector)
  );

  svpwm_duty #(
    .COUNT_BITS (COUNT_BITS)
  ) u_duty (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (idx_valid),
    .m_i          (m),
    .alpha_i      (alpha),
    .sector_i     (sector),
    .period_i     (period_q),
    .done_o       (done_o),
    .duty_a_o     (duty_a_o),
    .duty_b_o     (duty_b_o),
    .duty_c_o     (duty_c_o),
    .sector_num_o (sector_num_o)
  );

endmodule

[test/svpwm_checker.sv]
`timescale 1ns / 1ps

module svpwm_checker import svpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] volt_q_i,
  input  logic signed [15:0] volt_d_i,
  input  logic [15:0]        elec_angle_i,
  input  logic               done_o,
  input  logic [15:0]        duty_a_o,
  input  logic [15:0]        duty_b_o,
  input  logic [15:0]        duty_c_o,
  input  logic [2:0]         sector_num_o,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 err_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic [15:0] duty_a;
    logic [15:0] duty_b;
    logic [15:0] duty_c;
    logic [2:0]  sector;
  } duty_set_t;

  duty_set_t   duty_queue[$];
  logic [14:0] supply_q;
  logic [15:0] period_q;
  int          err_count;

  assign err_count_o = err_count;
  assign pending_o   = duty_queue.size();

  // rotation-mode cordic, result in q30
  function automatic longint sine_q30(longint beta);
    longint x, y, z, dx, dy;
    x = CORDIC_K_Q30;
    y = 0;
    z = beta;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ARC_TAB[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ARC_TAB[i]);
      end
    end
    return y;
  endfunction

  // q30 duty fraction to saturated compare count
  function automatic logic [15:0] duty_count(longint t, longint unsigned period);
    longint unsigned f, v;
    if (t < 0) return 16'd0;
    f = longint'(t) >> 14;
    v = (f * period) >> 16;
    if (v > period) v = period;
    return v[15:0];
  endfunction

  function automatic duty_set_t svpwm_duties(logic signed [15:0] q_in,
                                             logic signed [15:0] d_in,
                                             logic [15:0] ang_in);
    longint q, d, m, supply, x, y, dx, dy, t1, t2, t0, half, ta, tb, tc, alpha;
    longint unsigned sum, v, res, bitv, mag, angv, six, idx, r;
    logic [31:0] theta, phi;
    logic [2:0]  sector;
    duty_set_t   o;
    q = q_in;
    d = d_in;
    theta = {ang_in, 16'h0};
    supply = (supply_q == 0) ? 1 : longint'(supply_q);
    if (d != 0) begin
      // magnitude by integer root
      sum = longint'(q * q + d * d);
      v = sum << 16;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      mag = res;
      m = longint'((mag << 8) / longint'(supply));
      // vectoring cordic for atan2(q, d)
      x = d * 4194304;
      y = q * 4194304;
      phi = 32'h0;
      if (x < 0) begin
        x = -x;
        y = -y;
        phi = HALF_TURN;
      end
      for (int i = 0; i < 24; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          phi = phi + ARC_TAB[i];
        end else begin
          x = x - dx;
          y = y + dy;
          phi = phi - ARC_TAB[i];
        end
      end
      theta = theta + phi;
    end else begin
      m = (q * 65536) / supply;
      theta = theta + QUARTER_TURN;
    end
    if (m > 37814) m = 37814;
    if (m < -37814) m = -37814;

    // sector split
    angv = theta >> 16;
    six = angv * 6;
    idx = six >> 16;
    r = six - (idx << 16);
    sector = idx[2:0] + 3'd1;
    alpha = longint'((r << 16) / 6);

    t1 = (((sine_q30(longint'(SIXTY_DEG) - alpha) * SQRT3_Q30) >>> 30) * m) >>> 16;
    t2 = (((sine_q30(alpha) * SQRT3_Q30) >>> 30) * m) >>> 16;
    t0 = 64'sd1073741824 - t1 - t2;
    half = t0 >>> 1;

    case (sector)
      SECTOR_1: begin ta = t1 + t2 + half; tb = t2 + half; tc = half; end
      SECTOR_2: begin ta = t1 + half; tb = t1 + t2 + half; tc = half; end
      SECTOR_3: begin ta = half; tb = t1 + t2 + half; tc = t2 + half; end
      SECTOR_4: begin ta = half; tb = t1 + half; tc = t1 + t2 + half; end
      SECTOR_5: begin ta = t2 + half; tb = half; tc = t1 + t2 + half; end
      SECTOR_6: begin ta = t1 + t2 + half; tb = half; tc = t1 + half; end
      default: begin ta = 0; tb = 0; tc = 0; end
    endcase
    o.duty_a = duty_count(ta, period_q);
    o.duty_b = duty_count(tb, period_q);
    o.duty_c = duty_count(tc, period_q);
    o.sector = sector;
    return o;
  endfunction

  // track registers, predict accepted commands, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    duty_set_t exp_set;
    if (!rst_ni) begin
      supply_q = SUPPLY_RST;
      period_q = PERIOD_RST;
      duty_queue.delete();
      err_count = 0;
    end else begin
      if (done_o) begin
        if (duty_queue.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result a=%0d b=%0d c=%0d sector=%0d",
                     duty_a_o, duty_b_o, duty_c_o, sector_num_o);
        end else begin
          exp_set = duty_queue.pop_front();
          if (exp_set.duty_a !== duty_a_o || exp_set.duty_b !== duty_b_o ||
              exp_set.duty_c !== duty_c_o || exp_set.sector !== sector_num_o) begin
            err_count++;
            if (err_count <= 10)
              $display({"mismatch: expected a=%0d b=%0d c=%0d sector=%0d, ",
                        "got a=%0d b=%0d c=%0d sector=%0d"},
                       exp_set.duty_a, exp_set.duty_b, exp_set.duty_c, exp_set.sector,
                       duty_a_o, duty_b_o, duty_c_o, sector_num_o);
          end
        end
      end
      if (start && !busy)
        duty_queue.push_back(svpwm_duties(volt_q_i, volt_d_i, elec_angle_i));
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_SUPPLY) supply_q = cfg_data_i[14:0];
        else if (cfg_index_i == CFG_PERIOD) period_q = cfg_data_i;
      end
    end
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench import svpwm_pkg::*;;

  localparam int IDLE_LIMIT = 5000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] volt_q_i = '0;
  logic signed [15:0] volt_d_i = '0;
  logic [15:0]        elec_angle_i = '0;
  logic               done_o;
  logic [15:0]        duty_a_o, duty_b_o, duty_c_o;
  logic [2:0]         sector_num_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  int                 err_count, pending;
  int                 idle_cycles;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  space_vector_pwm_duty u_top (.*);

  svpwm_checker u_checker (.*, .err_count_o(err_count), .pending_o(pending));

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one command transaction after a random gap; start stays high on back-to-back
  task automatic send_vector(logic signed [15:0] q, logic signed [15:0] d, logic [15:0] a);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    volt_q_i <= q;
    volt_d_i <= d;
    elec_angle_i <= a;
    do @(posedge clk_i); while (busy);
  endtask

  // stop sending and let every pending result arrive
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_vectors(int n);
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 60)
        send_vector(16'($urandom), 16'($urandom), 16'($urandom));
      else if (kind < 80)
        send_vector(16'($urandom), 16'sd0, 16'($urandom));
      else
        send_vector(16'($signed($urandom_range(0, 2047)) - 1024),
                    16'($signed($urandom_range(0, 2047)) - 1024), 16'($urandom));
      // one hold-off until the pipeline is empty
      if (i == n / 2 && n > 20) drain();
    end
  endtask

  initial begin
    logic [15:0] supply_set [5];
    logic [15:0] period_set [5];
    supply_set = '{16'd1, 16'd32767, 16'd0, 16'd500, 16'hFFFF};
    period_set = '{16'd65535, 16'd1, 16'd1000, 16'd65535, 16'd257};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, simple and magnitude paths, each sector
    send_vector(16'sd0, 16'sd0, 16'd0);
    send_vector(16'sd32767, 16'sd0, 16'd0);
    send_vector(-16'sd32768, 16'sd0, 16'd65535);
    send_vector(16'sd0, 16'sd32767, 16'd0);
    send_vector(16'sd0, -16'sd32768, 16'd32768);
    send_vector(16'sd32767, 16'sd32767, 16'd65535);
    send_vector(-16'sd32768, -16'sd32768, 16'd0);
    send_vector(-16'sd32768, 16'sd32767, 16'd16384);
    send_vector(16'sd1, -16'sd1, 16'd49152);
    send_vector(-16'sd1, 16'sd0, 16'd1);
    send_vector(16'sd256, 16'sd0, 16'd0);
    for (int k = 0; k < 6; k++)
      send_vector(16'sd1000, 16'sd0, 16'(k * 10923 + 5000));
    for (int k = 0; k < 6; k++)
      send_vector(16'sd300, 16'sd300, 16'(k * 10923));
    random_vectors(100);
    drain();

    // register settings, zero supply and extremes among them
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_SUPPLY, supply_set[s]);
      write_reg(CFG_PERIOD, period_set[s]);
      random_vectors(100);
      drain();
    end
    write_reg(CFG_SUPPLY, 16'($urandom_range(1, 32767)));
    write_reg(CFG_PERIOD, 16'($urandom_range(1, 65535)));
    random_vectors(80);
    drain();

    if (err_count == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/svpwm_pkg.sv
rtl/core/svpwm_front.sv
rtl/core/svpwm_queue.sv
rtl/core/svpwm_index.sv
rtl/core/svpwm_angle.sv
rtl/core/svpwm_duty.sv
rtl/core/space_vector_pwm_duty.sv
test/svpwm_checker.sv
test/testbench.sv
